// ===== rtl/core/cov_pkg.sv =====
// Package for the cell outflux volume block: payload types, register and slot codes.
// Depends on nothing; every rtl/core file refers to it by scoped names.
`default_nettype none
package cov_pkg;

    localparam int NumSlots   = 26;
    localparam int NumOffSlots = 18;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_WIDTH_X   = 2'd1,
        REG_WIDTH_Y   = 2'd2,
        REG_WIDTH_Z   = 2'd3
    } reg_idx_t;

    // Distance codes.
    localparam logic [3:0] D_TOP = 4'd0, D_BOT = 4'd1, D_RIGHT = 4'd2, D_LEFT = 4'd3;
    localparam logic [3:0] D_FRONT = 4'd4, D_BACK = 4'd5, D_XT = 4'd6, D_YT = 4'd7;
    localparam logic [3:0] D_ZT = 4'd8;

    // Offset codes.
    localparam logic [3:0] O_RX = 4'd0, O_RXR = 4'd1, O_RXL = 4'd2, O_RY = 4'd3;
    localparam logic [3:0] O_RYT = 4'd4, O_RYB = 4'd5, O_RZ = 4'd6, O_RZF = 4'd7;
    localparam logic [3:0] O_RZB = 4'd8;

    typedef struct packed {
        logic signed [31:0] u_low_face;
        logic signed [31:0] u_high_face;
        logic signed [31:0] v_low_face;
        logic signed [31:0] v_high_face;
        logic signed [31:0] w_low_face;
        logic signed [31:0] w_high_face;
    } in_word_t;

    typedef struct packed {
        logic        [4:0]  flux_slot;
        logic signed [31:0] flux_volume;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic               offsets_valid;
        logic               last_of_cell;
        logic               volume_exceeded;
    } out_word_t;

    typedef struct packed {
        logic [30:0] time_step;
        logic [30:0] width_x;
        logic [30:0] width_y;
        logic [30:0] width_z;
    } cfg_t;

    // Per-cell geometry latched by the front end: nine distances, nine offsets.
    typedef struct packed {
        logic signed [8:0][31:0] span;
        logic signed [8:0][31:0] offs;
    } geom_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Q16.16 rescale of a full product, floor and saturate.
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [65:0] s;
        s = $signed({{2{p[63]}}, p}) >>> 16;
        return sat32(s);
    endfunction

    function automatic logic [11:0] vol_factors(input logic [4:0] k);
        case (k)
            5'd0:  return {D_TOP, D_XT, D_ZT};
            5'd1:  return {D_BOT, D_XT, D_ZT};
            5'd2:  return {D_RIGHT, D_YT, D_ZT};
            5'd3:  return {D_LEFT, D_YT, D_ZT};
            5'd4:  return {D_FRONT, D_XT, D_YT};
            5'd5:  return {D_BACK, D_XT, D_YT};
            5'd6:  return {D_TOP, D_RIGHT, D_ZT};
            5'd7:  return {D_TOP, D_XT, D_FRONT};
            5'd8:  return {D_TOP, D_LEFT, D_ZT};
            5'd9:  return {D_TOP, D_XT, D_BACK};
            5'd10: return {D_BOT, D_RIGHT, D_ZT};
            5'd11: return {D_BOT, D_XT, D_FRONT};
            5'd12: return {D_BOT, D_LEFT, D_ZT};
            5'd13: return {D_BOT, D_XT, D_BACK};
            5'd14: return {D_YT, D_RIGHT, D_BACK};
            5'd15: return {D_YT, D_RIGHT, D_FRONT};
            5'd16: return {D_YT, D_LEFT, D_BACK};
            5'd17: return {D_YT, D_LEFT, D_FRONT};
            5'd18: return {D_TOP, D_RIGHT, D_BACK};
            5'd19: return {D_TOP, D_RIGHT, D_FRONT};
            5'd20: return {D_TOP, D_LEFT, D_BACK};
            5'd21: return {D_TOP, D_LEFT, D_FRONT};
            5'd22: return {D_BOT, D_RIGHT, D_BACK};
            5'd23: return {D_BOT, D_RIGHT, D_FRONT};
            5'd24: return {D_BOT, D_LEFT, D_BACK};
            default: return {D_BOT, D_LEFT, D_FRONT};
        endcase
    endfunction

    function automatic logic [11:0] off_sel(input logic [4:0] k);
        case (k)
            5'd0:  return {O_RX, O_RYT, O_RZ};
            5'd1:  return {O_RX, O_RYB, O_RZ};
            5'd2:  return {O_RXR, O_RY, O_RZ};
            5'd3:  return {O_RXL, O_RY, O_RZ};
            5'd4:  return {O_RX, O_RY, O_RZF};
            5'd5:  return {O_RX, O_RY, O_RZB};
            5'd6:  return {O_RXR, O_RYT, O_RZ};
            5'd7:  return {O_RX, O_RYT, O_RZF};
            5'd8:  return {O_RXL, O_RYT, O_RZ};
            5'd9:  return {O_RX, O_RYT, O_RZB};
            5'd10: return {O_RXR, O_RYB, O_RZ};
            5'd11: return {O_RX, O_RYB, O_RZF};
            5'd12: return {O_RXL, O_RYB, O_RZ};
            5'd13: return {O_RX, O_RYB, O_RZB};
            5'd14: return {O_RXR, O_RY, O_RZB};
            5'd15: return {O_RXR, O_RY, O_RZF};
            5'd16: return {O_RXL, O_RY, O_RZB};
            default: return {O_RXL, O_RY, O_RZF};
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cov_front.sv =====
// Front end: per-cell distances, leftover widths and centroid offsets, three stages.
// Depends on cov_pkg.
`default_nettype none
module cov_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cov_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    input  wire cov_pkg::in_word_t in_word,
    input  wire logic             adv,
    output logic                  geom_valid,
    output cov_pkg::geom_t        geom
);
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [5:0][63:0]     prod_reg;
    logic signed [5:0][31:0]     d_reg;
    cov_pkg::geom_t              geom_reg;
    logic signed [5:0][31:0]     d_next;
    cov_pkg::geom_t              geom_next;
    logic signed [31:0]          vel [6];
    logic signed [32:0]          wx, wy, wz;

    assign vel[0] = in_word.u_low_face;
    assign vel[1] = in_word.u_high_face;
    assign vel[2] = in_word.v_low_face;
    assign vel[3] = in_word.v_high_face;
    assign vel[4] = in_word.w_low_face;
    assign vel[5] = in_word.w_high_face;

    // Even entries are low faces: negated product gives the outward distance.
    always_comb
    begin
        logic signed [63:0] p;
        logic signed [31:0] q;
        for (int i = 0; i < 6; i++)
        begin
            p = prod_reg[i];
            if (i % 2 == 0)
                p = -p;
            q = cov_pkg::qscale(p);
            d_next[i] = q[31] ? 32'sd0 : q;
        end
    end

    assign wx = {2'b00, cfg.width_x};
    assign wy = {2'b00, cfg.width_y};
    assign wz = {2'b00, cfg.width_z};

    function automatic logic signed [31:0] half(input logic signed [33:0] a);
        return cov_pkg::sat32($signed({{32{a[33]}}, a}) >>> 1);
    endfunction

    function automatic logic signed [31:0] left(input logic signed [32:0] w,
                                                 input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [33:0] s;
        s = {w[32], w} - {{2{a[31]}}, a} - {{2{b[31]}}, b};
        return cov_pkg::sat32({{32{s[33]}}, s});
    endfunction

    always_comb
    begin
        // d_reg order: 0 left,1 right,2 bottom,3 top,4 back,5 front
        geom_next.span[cov_pkg::D_LEFT]  = d_reg[0];
        geom_next.span[cov_pkg::D_RIGHT] = d_reg[1];
        geom_next.span[cov_pkg::D_BOT]   = d_reg[2];
        geom_next.span[cov_pkg::D_TOP]   = d_reg[3];
        geom_next.span[cov_pkg::D_BACK]  = d_reg[4];
        geom_next.span[cov_pkg::D_FRONT] = d_reg[5];
        geom_next.span[cov_pkg::D_XT] = left(wx, d_reg[1], d_reg[0]);
        geom_next.span[cov_pkg::D_YT] = left(wy, d_reg[3], d_reg[2]);
        geom_next.span[cov_pkg::D_ZT] = left(wz, d_reg[5], d_reg[4]);
        geom_next.offs[cov_pkg::O_RX]  = half({{2{d_reg[0][31]}}, d_reg[0]}
                                             - {{2{d_reg[1][31]}}, d_reg[1]});
        geom_next.offs[cov_pkg::O_RXR] = half({wx[32], wx} - {{2{d_reg[1][31]}}, d_reg[1]});
        geom_next.offs[cov_pkg::O_RXL] = half({{2{d_reg[0][31]}}, d_reg[0]} - {wx[32], wx});
        geom_next.offs[cov_pkg::O_RY]  = half({{2{d_reg[2][31]}}, d_reg[2]}
                                             - {{2{d_reg[3][31]}}, d_reg[3]});
        geom_next.offs[cov_pkg::O_RYT] = half({wy[32], wy} - {{2{d_reg[3][31]}}, d_reg[3]});
        geom_next.offs[cov_pkg::O_RYB] = half({{2{d_reg[2][31]}}, d_reg[2]} - {wy[32], wy});
        geom_next.offs[cov_pkg::O_RZ]  = half({{2{d_reg[4][31]}}, d_reg[4]}
                                             - {{2{d_reg[5][31]}}, d_reg[5]});
        geom_next.offs[cov_pkg::O_RZF] = half({wz[32], wz} - {{2{d_reg[5][31]}}, d_reg[5]});
        geom_next.offs[cov_pkg::O_RZB] = half({{2{d_reg[4][31]}}, d_reg[4]} - {wz[32], wz});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
                prod_reg[i] <= vel[i] * $signed({1'b0, cfg.time_step});
            d_reg    <= d_next;
            geom_reg <= geom_next;
        end
    end

    assign geom_valid = s3_valid_reg;
    assign geom       = geom_reg;
endmodule
`default_nettype wire

// ===== rtl/core/cov_volume.sv =====
// Volume pipeline: slot sequencer, two multiply stages, running total and output register.
// Depends on cov_pkg.
`default_nettype none
module cov_volume (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cov_pkg::cfg_t     cfg,
    input  wire logic              geom_valid,
    input  wire cov_pkg::geom_t    geom,
    output logic                   geom_take,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output cov_pkg::out_word_t     out_word
);
    // Stage A: select factors; B: first product; C: rescale, second product;
    // D: rescale, accumulate, output register.
    logic [4:0]              slot_reg;
    logic                    a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [4:0]              a_slot_reg, b_slot_reg, c_slot_reg;
    logic signed [31:0]      a_f0_reg, a_f1_reg, a_f2_reg;
    logic signed [31:0]      b_f2_reg;
    logic signed [63:0]      b_p_reg, c_p_reg;
    logic signed [2:0][31:0] a_off_reg, b_off_reg, c_off_reg;
    logic signed [63:0]      cv_p1_reg, cv_p2_reg;
    logic signed [31:0]      cell_vol_reg;
    logic signed [39:0]      total_reg;
    cov_pkg::out_word_t      out_reg;
    logic                    adv;
    logic [11:0]             vf, os;
    logic signed [31:0]      vol_c;
    logic signed [39:0]      total_next;

    assign adv       = !d_valid_reg || !out_stall;
    assign geom_take = adv && geom_valid && slot_reg == 5'(cov_pkg::NumSlots - 1);
    assign vf = cov_pkg::vol_factors(slot_reg);
    assign os = cov_pkg::off_sel(slot_reg);
    assign vol_c = cov_pkg::qscale(c_p_reg);
    assign total_next = (c_slot_reg == 5'd0 ? 40'sd0 : total_reg) + 40'(vol_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= 5'd0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (geom_valid)
                slot_reg <= geom_take ? 5'd0 : slot_reg + 5'd1;
            a_valid_reg <= geom_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Cell volume is static between config writes; computed alongside.
        cv_p1_reg    <= $signed({1'b0, cfg.width_x}) * $signed({1'b0, cfg.width_y});
        cv_p2_reg    <= cov_pkg::qscale(cv_p1_reg) * $signed({1'b0, cfg.width_z});
        cell_vol_reg <= cov_pkg::qscale(cv_p2_reg);
        if (adv)
        begin
            a_slot_reg <= slot_reg;
            a_f0_reg   <= geom.span[vf[11:8]];
            a_f1_reg   <= geom.span[vf[7:4]];
            a_f2_reg   <= geom.span[vf[3:0]];
            a_off_reg[2] <= geom.offs[os[11:8]];
            a_off_reg[1] <= geom.offs[os[7:4]];
            a_off_reg[0] <= geom.offs[os[3:0]];

            b_slot_reg <= a_slot_reg;
            b_p_reg    <= a_f0_reg * a_f1_reg;
            b_f2_reg   <= a_f2_reg;
            b_off_reg  <= a_off_reg;

            c_slot_reg <= b_slot_reg;
            c_p_reg    <= cov_pkg::qscale(b_p_reg) * b_f2_reg;
            c_off_reg  <= b_off_reg;

            if (c_valid_reg)
                total_reg <= total_next;
            out_reg.flux_slot     <= c_slot_reg;
            out_reg.flux_volume   <= vol_c;
            out_reg.offsets_valid <= c_slot_reg < 5'(cov_pkg::NumOffSlots);
            out_reg.offset_x <= c_slot_reg < 5'(cov_pkg::NumOffSlots) ? c_off_reg[2] : 32'sd0;
            out_reg.offset_y <= c_slot_reg < 5'(cov_pkg::NumOffSlots) ? c_off_reg[1] : 32'sd0;
            out_reg.offset_z <= c_slot_reg < 5'(cov_pkg::NumOffSlots) ? c_off_reg[0] : 32'sd0;
            out_reg.last_of_cell  <= c_slot_reg == 5'(cov_pkg::NumSlots - 1);
            out_reg.volume_exceeded <= c_slot_reg == 5'(cov_pkg::NumSlots - 1)
                                       && total_next > 40'(cell_vol_reg);
        end
    end

    assign out_valid = d_valid_reg;
    assign out_word  = out_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < 5'(cov_pkg::NumSlots)) else $error("slot counter out of range");
    a_take_last: assert property (@(posedge clk) disable iff (!rst_n)
        geom_take |-> slot_reg == 5'(cov_pkg::NumSlots - 1)) else $error("early take");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word)) else $error("output moved");
endmodule
`default_nettype wire

// ===== rtl/core/cell_outflux_volumes_top.sv =====
// Top level of the cell outflux volume block: config registers, front end, volume pipeline.
// Depends on cov_pkg, cov_front and cov_volume.
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | cov_pkg::in_word_t
//   out     | out       | out_valid/out_stall| cov_pkg::out_word_t
// A cell is accepted once all 26 of its slots are issued.
// The volume multiplier chain emits one slot a cycle while the output is not stalled.
// Reset clears valid bits and loads the register defaults; no clearing pass.
// An output stall freezes the volume stages and a loaded front end; no word is lost.
`default_nettype none
module cell_outflux_volumes_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire cov_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cov_pkg::out_word_t      out_word
);
    cov_pkg::cfg_t   cfg_reg;
    logic            geom_valid, geom_take, front_adv;
    cov_pkg::geom_t  geom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step <= 31'd0;
            cfg_reg.width_x   <= 31'd65536;
            cfg_reg.width_y   <= 31'd65536;
            cfg_reg.width_z   <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cov_pkg::REG_TIME_STEP: cfg_reg.time_step <= cfg_data;
                cov_pkg::REG_WIDTH_X:   cfg_reg.width_x   <= cfg_data;
                cov_pkg::REG_WIDTH_Y:   cfg_reg.width_y   <= cfg_data;
                default:                cfg_reg.width_z   <= cfg_data;
            endcase
        end
    end

    // The front end moves when its last stage is empty or being taken.
    assign front_adv = !geom_valid || geom_take;
    assign in_stall  = !front_adv;

    cov_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .in_valid(in_valid), .in_word(in_word),
        .adv(front_adv), .geom_valid(geom_valid), .geom(geom)
    );

    cov_volume u_volume (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .geom_valid(geom_valid), .geom(geom),
        .geom_take(geom_take), .out_valid(out_valid), .out_stall(out_stall),
        .out_word(out_word)
    );
endmodule
`default_nettype wire

// ===== bench/cell_outflux_volumes_top_tb.sv =====
// Testbench for cell_outflux_volumes_top: drives cells of face velocities and checks
// all 26 flux words of each cell against an in-bench predictor. Depends on cov_pkg.
`default_nettype none
module cell_outflux_volumes_top_tb;
    import cov_pkg::*;

    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;

    cell_outflux_volumes_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    // Shadow copy of the registers.
    longint step_reg;
    longint width_reg [3];

    out_word_t flux_q [$];
    int err_count = 0;
    int burst_left;
    int quiet_left = 0;

    // Factor and offset selections per slot, in slot order.
    logic [3:0] vol_tab [26][3] = '{
        '{D_TOP, D_XT, D_ZT}, '{D_BOT, D_XT, D_ZT}, '{D_RIGHT, D_YT, D_ZT},
        '{D_LEFT, D_YT, D_ZT}, '{D_FRONT, D_XT, D_YT}, '{D_BACK, D_XT, D_YT},
        '{D_TOP, D_RIGHT, D_ZT}, '{D_TOP, D_XT, D_FRONT}, '{D_TOP, D_LEFT, D_ZT},
        '{D_TOP, D_XT, D_BACK}, '{D_BOT, D_RIGHT, D_ZT}, '{D_BOT, D_XT, D_FRONT},
        '{D_BOT, D_LEFT, D_ZT}, '{D_BOT, D_XT, D_BACK}, '{D_YT, D_RIGHT, D_BACK},
        '{D_YT, D_RIGHT, D_FRONT}, '{D_YT, D_LEFT, D_BACK}, '{D_YT, D_LEFT, D_FRONT},
        '{D_TOP, D_RIGHT, D_BACK}, '{D_TOP, D_RIGHT, D_FRONT}, '{D_TOP, D_LEFT, D_BACK},
        '{D_TOP, D_LEFT, D_FRONT}, '{D_BOT, D_RIGHT, D_BACK}, '{D_BOT, D_RIGHT, D_FRONT},
        '{D_BOT, D_LEFT, D_BACK}, '{D_BOT, D_LEFT, D_FRONT}
    };
    logic [3:0] off_tab [18][3] = '{
        '{O_RX, O_RYT, O_RZ}, '{O_RX, O_RYB, O_RZ}, '{O_RXR, O_RY, O_RZ},
        '{O_RXL, O_RY, O_RZ}, '{O_RX, O_RY, O_RZF}, '{O_RX, O_RY, O_RZB},
        '{O_RXR, O_RYT, O_RZ}, '{O_RX, O_RYT, O_RZF}, '{O_RXL, O_RYT, O_RZ},
        '{O_RX, O_RYT, O_RZB}, '{O_RXR, O_RYB, O_RZ}, '{O_RX, O_RYB, O_RZF},
        '{O_RXL, O_RYB, O_RZ}, '{O_RX, O_RYB, O_RZB}, '{O_RXR, O_RY, O_RZB},
        '{O_RXR, O_RY, O_RZF}, '{O_RXL, O_RY, O_RZB}, '{O_RXL, O_RY, O_RZF}
    };

    function automatic longint clamp32(longint x);
        if (x > QMax) return QMax;
        if (x < QMin) return QMin;
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> 16);
    endfunction

    function automatic longint half_gap(longint a, longint b);
        longint d;
        d = a - b;
        return clamp32(d >>> 1);
    endfunction

    function automatic longint pos_part(longint x);
        return (x > 0) ? x : 0;
    endfunction

    // Works out the 26 flux words of one cell and queues them.
    task automatic predict_cell_flux(input in_word_t w);
        longint span [9];
        longint offs [9];
        longint vols [26];
        longint total;
        longint cell_vol;
        out_word_t r;
        total = 0;
        span[D_RIGHT] = pos_part(fx_mul(longint'(w.u_high_face), step_reg));
        span[D_LEFT]  = pos_part(clamp32((-(longint'(w.u_low_face) * step_reg)) >>> 16));
        span[D_TOP]   = pos_part(fx_mul(longint'(w.v_high_face), step_reg));
        span[D_BOT]   = pos_part(clamp32((-(longint'(w.v_low_face) * step_reg)) >>> 16));
        span[D_FRONT] = pos_part(fx_mul(longint'(w.w_high_face), step_reg));
        span[D_BACK]  = pos_part(clamp32((-(longint'(w.w_low_face) * step_reg)) >>> 16));
        span[D_XT] = clamp32(width_reg[0] - span[D_RIGHT] - span[D_LEFT]);
        span[D_YT] = clamp32(width_reg[1] - span[D_TOP] - span[D_BOT]);
        span[D_ZT] = clamp32(width_reg[2] - span[D_FRONT] - span[D_BACK]);
        offs[O_RX]  = half_gap(span[D_LEFT], span[D_RIGHT]);
        offs[O_RXR] = half_gap(width_reg[0], span[D_RIGHT]);
        offs[O_RXL] = half_gap(span[D_LEFT], width_reg[0]);
        offs[O_RY]  = half_gap(span[D_BOT], span[D_TOP]);
        offs[O_RYT] = half_gap(width_reg[1], span[D_TOP]);
        offs[O_RYB] = half_gap(span[D_BOT], width_reg[1]);
        offs[O_RZ]  = half_gap(span[D_BACK], span[D_FRONT]);
        offs[O_RZF] = half_gap(width_reg[2], span[D_FRONT]);
        offs[O_RZB] = half_gap(span[D_BACK], width_reg[2]);
        for (int k = 0; k < 26; k++)
        begin
            vols[k] = fx_mul(fx_mul(span[vol_tab[k][0]], span[vol_tab[k][1]]),
                             span[vol_tab[k][2]]);
            total += vols[k];
        end
        cell_vol = fx_mul(fx_mul(width_reg[0], width_reg[1]), width_reg[2]);
        for (int k = 0; k < 26; k++)
        begin
            r = '0;
            r.flux_slot = 5'(k);
            r.flux_volume = 32'(vols[k]);
            if (k < 18)
            begin
                r.offset_x = 32'(offs[off_tab[k][0]]);
                r.offset_y = 32'(offs[off_tab[k][1]]);
                r.offset_z = 32'(offs[off_tab[k][2]]);
                r.offsets_valid = 1'b1;
            end
            r.last_of_cell = (k == 25);
            r.volume_exceeded = (k == 25) && (total > cell_vol);
            flux_q = {flux_q, r};
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Result checker and output stall pattern.
    always @(posedge clk)
    begin
        out_word_t want;
        if (out_valid && !out_stall)
        begin
            if (flux_q.size() == 0)
                report("unexpected word", 32'(out_word.flux_slot), 32'd0);
            else
            begin
                want = flux_q.pop_front();
                if (out_word.flux_slot !== want.flux_slot)
                    report("flux_slot", 32'(out_word.flux_slot), 32'(want.flux_slot));
                if (out_word.flux_volume !== want.flux_volume)
                    report("flux_volume", out_word.flux_volume, want.flux_volume);
                if (out_word.offset_x !== want.offset_x)
                    report("offset_x", out_word.offset_x, want.offset_x);
                if (out_word.offset_y !== want.offset_y)
                    report("offset_y", out_word.offset_y, want.offset_y);
                if (out_word.offset_z !== want.offset_z)
                    report("offset_z", out_word.offset_z, want.offset_z);
                if (out_word.offsets_valid !== want.offsets_valid)
                    report("offsets_valid", 32'(out_word.offsets_valid),
                           32'(want.offsets_valid));
                if (out_word.last_of_cell !== want.last_of_cell)
                    report("last_of_cell", 32'(out_word.last_of_cell),
                           32'(want.last_of_cell));
                if (out_word.volume_exceeded !== want.volume_exceeded)
                    report("volume_exceeded", 32'(out_word.volume_exceeded),
                           32'(want.volume_exceeded));
            end
        end
        if (quiet_left > 0)
        begin
            quiet_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 40) == 0)
                quiet_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 60) == 0)
                quiet_left = 0;
            out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Sends one cell, with bursts separated by idle gaps.
    task automatic send_cell(input in_word_t w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        predict_cell_flux(w);
    endtask

    // Drains the pipeline, then writes one register.
    task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
        in_valid <= 1'b0;
        burst_left = 0;
        while (flux_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIME_STEP)
            step_reg = val;
        else
            width_reg[idx - 1] = val;
    endtask

    task automatic set_config(input logic [30:0] ts, input logic [30:0] wx,
                              input logic [30:0] wy, input logic [30:0] wz);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_WIDTH_X, wx);
        write_reg(REG_WIDTH_Y, wy);
        write_reg(REG_WIDTH_Z, wz);
    endtask

    function automatic logic [31:0] rand_velocity();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            2: return 32'($signed($urandom_range(0, 32'h200000)) - 32'sh100000);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
        endcase
    endfunction

    function automatic in_word_t rand_cell();
        in_word_t w;
        w.u_low_face = rand_velocity();
        w.u_high_face = rand_velocity();
        w.v_low_face = rand_velocity();
        w.v_high_face = rand_velocity();
        w.w_low_face = rand_velocity();
        w.w_high_face = rand_velocity();
        return w;
    endfunction

    function automatic in_word_t uniform_cell(input logic [31:0] lo, input logic [31:0] hi);
        return '{lo, hi, lo, hi, lo, hi};
    endfunction

    // Time step is zero after reset, so all outflow distances vanish.
    task automatic test_reset_defaults();
        send_cell(uniform_cell(32'h7FFFFFFF, 32'h80000000));
        send_cell(rand_cell());
    endtask

    task automatic test_field_extremes();
        set_config(31'h10000, 31'h10000, 31'h10000, 31'h10000);
        send_cell(uniform_cell(32'h0, 32'h0));
        send_cell(uniform_cell(32'h80000000, 32'h7FFFFFFF));
        send_cell(uniform_cell(32'h7FFFFFFF, 32'h80000000));
        send_cell(uniform_cell(32'hFFFFFFFF, 32'h00000001));
        send_cell(uniform_cell(32'hFFFF8000, 32'h00008000));
        send_cell('{32'hFFFFC000, 32'h4000, 32'h0, 32'h0, 32'h0, 32'h0});
        send_cell('{32'h0, 32'h0, 32'hFFFFC000, 32'h4000, 32'h0, 32'h0});
        send_cell('{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFFC000, 32'h4000});
        // Saturating steps and widths push products to the clamp.
        set_config(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_cell(uniform_cell(32'h80000000, 32'h7FFFFFFF));
        send_cell(uniform_cell(32'hFFFFFFFF, 32'h00000001));
        send_cell(uniform_cell(32'h0, 32'h0));
    endtask

    // Outflow wider than the cell leaves a negative leftover width.
    task automatic test_negative_leftover();
        set_config(31'h10000, 31'h8000, 31'h0, 31'h18000);
        send_cell(uniform_cell(32'hFFFF0000, 32'h10000));
        send_cell(uniform_cell(32'hFFF00000, 32'h100000));
        send_cell('{32'hFFFF8000, 32'h20000, 32'hFFFFF000, 32'h30000, 32'h0, 32'h8000});
        send_cell(uniform_cell(32'h80000000, 32'h7FFFFFFF));
    endtask

    task automatic test_random_cells(input int count);
        for (int i = 0; i < count; i++)
            send_cell(rand_cell());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word = '0;
        burst_left = 0;
        step_reg = 0;
        width_reg = '{65536, 65536, 65536};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_negative_leftover();

        set_config(31'h10000, 31'h10000, 31'h10000, 31'h10000);
        test_random_cells(50);
        set_config(31'h4000, 31'($urandom), 31'($urandom_range(0, 32'h40000)),
                   31'($urandom_range(0, 32'h40000)));
        test_random_cells(40);
        set_config(31'h7FFFFFFF, 31'h0, 31'h7FFFFFFF, 31'h0);
        test_random_cells(30);
        set_config(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
        test_random_cells(30);
        set_config(31'($urandom_range(1, 32'h20000)), 31'h20000, 31'h18000, 31'h10000);
        test_random_cells(50);

        in_valid <= 1'b0;
        while (flux_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
